// File: sv/hpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid_pkg
// Widths, reset values, register indexes and shared helpers of the heading
// regulator.
// ----------------------------------------------------------------------------
package hpid_pkg;

	localparam int RateW    = 16;
	localparam int YawW     = 17;
	localparam int PotW     = 12;
	localparam int GainW    = 16;
	localparam int AngW     = 24;
	localparam int Ang2W    = AngW + 2;
	localparam int DriveW   = 17;
	localparam int LimW     = 23;
	localparam int StepW    = 17;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 23;

	localparam logic [GainW-1:0] ErrLimRst  = 16'd25600;
	localparam logic [LimW-1:0]  SumLimRst  = 23'd25600;
	localparam logic [GainW-1:0] StepTimRst = 16'd6554;

	localparam logic signed [DriveW-1:0] DriveMax = 17'sd38400;
	localparam logic signed [AngW-1:0]   AngMax   = {1'b0, {(AngW-1){1'b1}}};
	localparam logic signed [AngW-1:0]   AngMin   = {1'b1, {(AngW-1){1'b0}}};

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PROP_GAIN   = 3'd0,
		CFG_INTEG_GAIN  = 3'd1,
		CFG_DERIV_GAIN  = 3'd2,
		CFG_ERROR_LIMIT = 3'd3,
		CFG_SUM_LIMIT   = 3'd4,
		CFG_STEP_TIME   = 3'd5,
		CFG_GAIN_SOURCE = 3'd6
	} cfg_idx_t;

	// one tick's target step and measurement, into the state stage
	typedef struct packed {
		logic signed [StepW-1:0] step;
		logic signed [YawW-1:0]  yaw;
		logic                    ki_zero;
	} step_t;

	// error terms out of the state stage
	typedef struct packed {
		logic signed [AngW-1:0] err;
		logic signed [AngW-1:0] sum;
		logic signed [AngW:0]   diff;
	} integ_res_t;

	// round(pot * 8192 / 4095) = 2*pot + floor((2*pot + 2047) / 4095)
	function automatic logic [GainW-1:0] pot_gain(input logic [PotW-1:0] pot);
		logic [PotW+1:0] twice;
		logic [PotW+1:0] biased;
		logic [1:0]      carry;
		twice  = {1'b0, pot, 1'b0};
		biased = twice + 14'd2047;
		if (biased >= 14'd8190)
			carry = 2'd2;
		else if (biased >= 14'd4095)
			carry = 2'd1;
		else
			carry = 2'd0;
		return GainW'(twice) + GainW'(carry);
	endfunction

	// clip a two-bit-wider value to the angle range
	function automatic logic signed [AngW-1:0] sat_ang(input logic signed [Ang2W-1:0] v);
		logic [2:0] top;
		top = v[Ang2W-1:AngW-1];
		if (top == 3'b000 || top == 3'b111)
			return v[AngW-1:0];
		else if (v[Ang2W-1])
			return AngMin;
		else
			return AngMax;
	endfunction

endpackage

// File: sv/hpid_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid channel interfaces
// Valid/ready channels for the measurement beat and the result beat.
// ----------------------------------------------------------------------------
interface hpid_in_if;
	import hpid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [RateW-1:0] turn_rate;
	logic                    reverse_drive;
	logic signed [YawW-1:0]  measured_yaw;
	logic [PotW-1:0]         pot_prop;
	logic [PotW-1:0]         pot_integ;
	logic [PotW-1:0]         pot_deriv;

	modport source (
		output valid, turn_rate, reverse_drive, measured_yaw, pot_prop, pot_integ, pot_deriv,
		input  ready
	);
	modport sink (
		input  valid, turn_rate, reverse_drive, measured_yaw, pot_prop, pot_integ, pot_deriv,
		output ready
	);
endinterface

interface hpid_out_if;
	import hpid_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DriveW-1:0] drive_out;
	logic signed [AngW-1:0]   error_now;

	modport source (
		output valid, drive_out, error_now,
		input  ready
	);
	modport sink (
		input  valid, drive_out, error_now,
		output ready
	);
endinterface

// File: sv/hpid_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid_state
// Target, error and separated integral update; holds the regulator state.
// ----------------------------------------------------------------------------
module hpid_state (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  hpid_pkg::step_t              stp,
	input  logic [hpid_pkg::GainW-1:0]   error_limit,
	input  logic [hpid_pkg::LimW-1:0]    sum_limit,
	output hpid_pkg::integ_res_t         res_s2
);
	import hpid_pkg::*;

	logic signed [AngW-1:0]  target_q;
	logic signed [AngW-1:0]  last_err_q;
	logic signed [AngW-1:0]  integ_q;

	logic signed [AngW-1:0]  target_nxt;
	logic signed [AngW-1:0]  err;
	logic signed [AngW:0]    err_wide;
	logic [AngW:0]           err_mag;
	logic signed [AngW-1:0]  lim_err;
	logic signed [AngW-1:0]  sep;
	logic signed [Ang2W-1:0] sum_raw;
	logic signed [Ang2W-1:0] lim_sum;
	logic signed [AngW-1:0]  sum_nxt;
	logic signed [AngW:0]    diff;

	always_comb begin
		target_nxt = sat_ang(Ang2W'(target_q) + Ang2W'(stp.step));
		err        = sat_ang(Ang2W'(target_nxt) - Ang2W'(stp.yaw));
		err_wide   = (AngW+1)'(err);
		err_mag    = err_wide[AngW] ? $unsigned(-err_wide) : $unsigned(err_wide);
		lim_err    = $signed(AngW'(error_limit));

		// integral separation: large errors only add the limit
		if (err_mag <= (AngW+1)'(error_limit))
			sep = err;
		else if (err[AngW-1])
			sep = -lim_err;
		else
			sep = lim_err;

		sum_raw = Ang2W'(integ_q) + Ang2W'(sep);
		lim_sum = $signed(Ang2W'(sum_limit));
		if (stp.ki_zero)
			sum_raw = '0;
		if (sum_raw > lim_sum)
			sum_nxt = lim_sum[AngW-1:0];
		else if (sum_raw < -lim_sum)
			sum_nxt = AngW'(-lim_sum);
		else
			sum_nxt = sum_raw[AngW-1:0];

		diff = err_wide - (AngW+1)'(last_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			last_err_q <= '0;
			integ_q    <= '0;
		end else if (adv) begin
			target_q   <= target_nxt;
			last_err_q <= err;
			integ_q    <= sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.err  <= err;
			res_s2.sum  <= sum_nxt;
			res_s2.diff <= diff;
		end
	end

endmodule

// File: sv/heading_pid_with_integral_separation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_with_integral_separation
// Positional heading PID regulator with integral separation and clamp.
// ----------------------------------------------------------------------------
// in_ch carries one control tick per beat: turn rate, drive direction,
// measured yaw and three potentiometer readings. out_ch returns one beat
// per tick: the saturated drive and the current heading error.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata);
// write it only while no tick is in flight. Unknown indexes are ignored.
// A beat passes the registered stages in order: input register with the
// step multiply, state update stage, three gain multiplies, then the sum
// and output clip. A new beat is taken every cycle while in_ch.ready is high.
// Each stage moves on when the one after it is empty or moving, so the
// block keeps taking beats while a result waits, until all stages fill.
// When the receiver stalls with every stage full, in_ch.ready drops.
// Reset clears target heading, previous error and integral, empties the
// pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module heading_pid_with_integral_separation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [hpid_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [hpid_pkg::CfgDataW-1:0]   cfg_wdata,
	hpid_in_if.sink                         in_ch,
	hpid_out_if.source                      out_ch
);
	import hpid_pkg::*;

	localparam int ProdW = GainW + 1 + AngW;
	localparam int DiffW = GainW + 1 + AngW + 1;
	localparam int AccW  = DiffW + 2;
	localparam int ScW   = AccW - 12;

	// configuration
	logic [GainW-1:0] prop_gain_q;
	logic [GainW-1:0] integ_gain_q;
	logic [GainW-1:0] deriv_gain_q;
	logic [GainW-1:0] error_limit_q;
	logic [LimW-1:0]  sum_limit_q;
	logic [GainW-1:0] step_time_q;
	logic             gain_source_q;
	cfg_idx_t         cidx;

	assign cidx = cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			error_limit_q <= ErrLimRst;
			sum_limit_q   <= SumLimRst;
			step_time_q   <= StepTimRst;
			gain_source_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cidx)
				CFG_PROP_GAIN:   prop_gain_q   <= cfg_wdata[GainW-1:0];
				CFG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata[GainW-1:0];
				CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_wdata[GainW-1:0];
				CFG_ERROR_LIMIT: error_limit_q <= cfg_wdata[GainW-1:0];
				CFG_SUM_LIMIT:   sum_limit_q   <= cfg_wdata[LimW-1:0];
				CFG_STEP_TIME:   step_time_q   <= cfg_wdata[GainW-1:0];
				CFG_GAIN_SOURCE: gain_source_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4 = !v_s4 || out_ch.ready;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_ch.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: target step and gain selection
	logic signed [RateW+GainW:0] rate_prod;
	logic signed [StepW-1:0]     delta;
	logic [GainW-1:0]            kp_sel, ki_sel, kd_sel;
	step_t                       stp_s1;
	logic [GainW-1:0]            kp_s1, kd_s1;

	assign rate_prod = in_ch.turn_rate * $signed({1'b0, step_time_q});
	assign delta     = $signed(rate_prod[RateW+GainW:GainW]);
	assign kp_sel    = gain_source_q ? pot_gain(in_ch.pot_prop)  : prop_gain_q;
	assign ki_sel    = gain_source_q ? pot_gain(in_ch.pot_integ) : integ_gain_q;
	assign kd_sel    = gain_source_q ? pot_gain(in_ch.pot_deriv) : deriv_gain_q;

	logic [GainW-1:0] ki_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			stp_s1.step    <= in_ch.reverse_drive ? -delta : delta;
			stp_s1.yaw     <= in_ch.measured_yaw;
			stp_s1.ki_zero <= (ki_sel == '0);
			kp_s1          <= kp_sel;
			ki_s1          <= ki_sel;
			kd_s1          <= kd_sel;
		end
	end

	// stage 2: regulator state
	integ_res_t       res_s2;
	logic [GainW-1:0] kp_s2, ki_s2, kd_s2;

	hpid_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (v_s1 && adv_s2),
		.stp         (stp_s1),
		.error_limit (error_limit_q),
		.sum_limit   (sum_limit_q),
		.res_s2      (res_s2)
	);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			kp_s2 <= kp_s1;
			ki_s2 <= ki_s1;
			kd_s2 <= kd_s1;
		end
	end

	// stage 3: gain products
	logic signed [ProdW-1:0] prod_p_s3, prod_i_s3;
	logic signed [DiffW-1:0] prod_d_s3;
	logic signed [AngW-1:0]  err_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			prod_p_s3 <= $signed({1'b0, kp_s2}) * res_s2.err;
			prod_i_s3 <= $signed({1'b0, ki_s2}) * res_s2.sum;
			prod_d_s3 <= $signed({1'b0, kd_s2}) * res_s2.diff;
			err_s3    <= res_s2.err;
		end
	end

	// stage 4: sum, Q.12 floor scaling and output clip
	logic signed [AccW-1:0]   acc;
	logic signed [ScW-1:0]    scaled;
	logic signed [DriveW-1:0] drive_nxt;
	logic signed [DriveW-1:0] drive_s4;
	logic signed [AngW-1:0]   err_s4;

	always_comb begin
		acc    = AccW'(prod_p_s3) + AccW'(prod_i_s3) + AccW'(prod_d_s3);
		scaled = $signed(acc[AccW-1:12]);
		if (scaled > ScW'(DriveMax))
			drive_nxt = DriveMax;
		else if (scaled < -ScW'(DriveMax))
			drive_nxt = -DriveMax;
		else
			drive_nxt = scaled[DriveW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			drive_s4 <= drive_nxt;
			err_s4   <= err_s3;
		end
	end

	assign out_ch.valid     = v_s4;
	assign out_ch.drive_out = drive_s4;
	assign out_ch.error_now = err_s4;

	// checks
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (drive_s4 <= DriveMax && drive_s4 >= -DriveMax))
		else $error("drive beyond output limit");

	a_ready_on_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> in_ch.ready)
		else $error("input stalled with an empty output stage");

	a_ki_zero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv_s2 && stp_s1.ki_zero) |=> (res_s2.sum == '0))
		else $error("integral not cleared with zero integral gain");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv_s4) |=> v_s4)
		else $error("result lost between product and output stage");

endmodule

// File: verif/hpid_regulator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid_regulator_checker
// Watches the tick and result channels and the register write port of the
// heading regulator, keeps its own copy of the target, integral and gains,
// and compares every result beat with the oldest outstanding tick.
// ----------------------------------------------------------------------------
module hpid_regulator_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [hpid_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hpid_pkg::CfgDataW-1:0] cfg_wdata,
	hpid_in_if                            in_ch,
	hpid_out_if                           out_ch,
	output int                            mismatch_count,
	output int                            in_flight
);
	import hpid_pkg::*;

	localparam longint AngHi    = (longint'(1) <<< (AngW - 1)) - 1;
	localparam longint AngLo    = -(longint'(1) <<< (AngW - 1));
	localparam longint DriveLim = longint'(DriveMax);

	typedef struct packed {
		logic signed [DriveW-1:0] drive;
		logic signed [AngW-1:0]   err;
	} pid_out_t;

	logic signed [AngW-1:0] target_hdg;
	logic signed [AngW-1:0] prev_err;
	logic signed [AngW-1:0] integ;
	logic [GainW-1:0]       kp_reg;
	logic [GainW-1:0]       ki_reg;
	logic [GainW-1:0]       kd_reg;
	logic [GainW-1:0]       err_lim;
	logic [LimW-1:0]        sum_lim;
	logic [GainW-1:0]       step_reg;
	logic                   pot_src;
	pid_out_t               regulator_out_q[$];

	function automatic longint clip_angle(input longint v);
		if (v > AngHi)
			return AngHi;
		if (v < AngLo)
			return AngLo;
		return v;
	endfunction

	// reading of 4095 maps to 2.0 in Q4.12, rounded to nearest
	function automatic longint pot_to_gain(input logic [PotW-1:0] pot);
		return (longint'(pot) * 8192 + 2047) / 4095;
	endfunction

	task automatic run_tick(
		input  logic signed [RateW-1:0] rate,
		input  logic                    rev,
		input  logic signed [YawW-1:0]  yaw,
		input  logic [PotW-1:0]         pot_p,
		input  logic [PotW-1:0]         pot_i,
		input  logic [PotW-1:0]         pot_d,
		output pid_out_t                res
	);
		longint kp, ki, kd, delta, tgt, e, mag, add, sum, lim, acc, drv;
		if (pot_src) begin
			kp = pot_to_gain(pot_p);
			ki = pot_to_gain(pot_i);
			kd = pot_to_gain(pot_d);
		end else begin
			kp = longint'(kp_reg);
			ki = longint'(ki_reg);
			kd = longint'(kd_reg);
		end
		// arithmetic shift floors negative steps
		delta = (longint'(rate) * longint'(step_reg)) >>> 16;
		tgt = rev ? longint'(target_hdg) - delta : longint'(target_hdg) + delta;
		target_hdg = AngW'(clip_angle(tgt));
		e = clip_angle(longint'(target_hdg) - longint'(yaw));
		mag = (e < 0) ? -e : e;
		// integral separation: large errors only add the threshold
		if (mag <= longint'(err_lim))
			add = e;
		else
			add = (e < 0) ? -longint'(err_lim) : longint'(err_lim);
		sum = longint'(integ) + add;
		if (ki == 0)
			sum = 0;
		lim = longint'(sum_lim);
		if (sum > lim)
			sum = lim;
		if (sum < -lim)
			sum = -lim;
		integ = AngW'(sum);
		acc = kp * e + ki * sum + kd * (e - longint'(prev_err));
		prev_err = AngW'(e);
		drv = acc >>> 12;
		if (drv > DriveLim)
			drv = DriveLim;
		if (drv < -DriveLim)
			drv = -DriveLim;
		res.drive = DriveW'(drv);
		res.err   = AngW'(e);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < 50)
			$display("hpid_regulator_checker: %s got %0d want %0d at %0t", what, got, want,
				$time);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pid_out_t want;
		pid_out_t fresh;
		if (!arst_n) begin
			target_hdg = '0;
			prev_err   = '0;
			integ      = '0;
			kp_reg     = '0;
			ki_reg     = '0;
			kd_reg     = '0;
			err_lim    = ErrLimRst;
			sum_lim    = SumLimRst;
			step_reg   = StepTimRst;
			pot_src    = 1'b0;
			regulator_out_q.delete();
		end else begin
			// result side first, so a beat leaving never pairs with one arriving
			if (out_ch.valid && out_ch.ready) begin
				if (regulator_out_q.size() == 0) begin
					report_mismatch("result beat with no tick outstanding, drive_out",
						longint'(out_ch.drive_out), 0);
				end else begin
					want = regulator_out_q.pop_front();
					if (out_ch.drive_out !== want.drive)
						report_mismatch("drive_out", longint'(out_ch.drive_out),
							longint'(want.drive));
					if (out_ch.error_now !== want.err)
						report_mismatch("error_now", longint'(out_ch.error_now),
							longint'(want.err));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				run_tick(in_ch.turn_rate, in_ch.reverse_drive, in_ch.measured_yaw,
					in_ch.pot_prop, in_ch.pot_integ, in_ch.pot_deriv, fresh);
				regulator_out_q.push_back(fresh);
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_PROP_GAIN:   kp_reg   = cfg_wdata[GainW-1:0];
					CFG_INTEG_GAIN:  ki_reg   = cfg_wdata[GainW-1:0];
					CFG_DERIV_GAIN:  kd_reg   = cfg_wdata[GainW-1:0];
					CFG_ERROR_LIMIT: err_lim  = cfg_wdata[GainW-1:0];
					CFG_SUM_LIMIT:   sum_lim  = cfg_wdata[LimW-1:0];
					CFG_STEP_TIME:   step_reg = cfg_wdata[GainW-1:0];
					CFG_GAIN_SOURCE: pot_src  = cfg_wdata[0];
					default: begin
					end
				endcase
			end
		end
		in_flight = regulator_out_q.size();
	end

endmodule

// File: verif/heading_pid_with_integral_separation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_with_integral_separation_tb
// Drives control ticks and register settings into the heading regulator:
// a directed run over the separation threshold, integral clamp, step
// rounding and output clip, then random phases with varied gains, limits
// and gain source, including target wind-up into both saturation ends.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module heading_pid_with_integral_separation_tb;
	import hpid_pkg::*;

	localparam int QuietLimit    = 1500;
	localparam int SettleCycles  = 8;
	localparam int HoldCycles    = 150;
	localparam int RandPhases    = 12;
	localparam int PhaseItems    = 95;
	localparam int WindUpItems   = 320;
	localparam int WindDownItems = 600;
	localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

	typedef enum int {
		PROF_NARROW,
		PROF_WIDE,
		PROF_WIND_UP,
		PROF_WIND_DOWN
	} motion_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;
	int                  tx_idle_pct;
	int                  rx_idle_pct;
	int                  hold_request = 0;
	int                  mismatch_count;
	int                  in_flight;

	hpid_in_if  in_ch ();
	hpid_out_if out_ch ();

	heading_pid_with_integral_separation u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	hpid_regulator_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.mismatch_count (mismatch_count),
		.in_flight      (in_flight)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// upper write-data bits are junk for the narrow registers
	task automatic write_settings(
		input logic [GainW-1:0] kp,
		input logic [GainW-1:0] ki,
		input logic [GainW-1:0] kd,
		input logic [GainW-1:0] elim,
		input logic [LimW-1:0]  slim,
		input logic [GainW-1:0] step,
		input logic             src
	);
		cfg_write(CFG_PROP_GAIN,   {(CfgDataW-GainW)'($urandom), kp});
		cfg_write(CFG_INTEG_GAIN,  {(CfgDataW-GainW)'($urandom), ki});
		cfg_write(CFG_DERIV_GAIN,  {(CfgDataW-GainW)'($urandom), kd});
		cfg_write(CFG_ERROR_LIMIT, {(CfgDataW-GainW)'($urandom), elim});
		cfg_write(CFG_SUM_LIMIT,   slim);
		cfg_write(CFG_STEP_TIME,   {(CfgDataW-GainW)'($urandom), step});
		cfg_write(CFG_GAIN_SOURCE, {(CfgDataW-1)'($urandom), src});
		cfg_write(CfgIdxSpare, CfgDataW'($urandom));
	endtask

	task automatic offer_tick(
		input logic signed [RateW-1:0] rate,
		input logic                    rev,
		input logic signed [YawW-1:0]  yaw,
		input logic [PotW-1:0]         pot_p,
		input logic [PotW-1:0]         pot_i,
		input logic [PotW-1:0]         pot_d
	);
		@(negedge clk);
		// idle cycle by cycle at the sender's rate
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid         = 1'b1;
		in_ch.turn_rate     = rate;
		in_ch.reverse_drive = rev;
		in_ch.measured_yaw  = yaw;
		in_ch.pot_prop      = pot_p;
		in_ch.pot_integ     = pot_i;
		in_ch.pot_deriv     = pot_d;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic drain_ticks();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (in_flight != 0)
			@(negedge clk);
	endtask

	function automatic logic [PotW-1:0] pick_pot();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? {PotW{1'b1}} : '0;
		return PotW'($urandom);
	endfunction

	// result side: random stalls, plus a long hold-off when requested
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("heading_pid_with_integral_separation_tb: done, errors");
		$finish;
	end

	initial begin
		motion_t                 prof;
		int                      n_items;
		logic signed [RateW-1:0] rate;
		logic                    rev;
		logic signed [YawW-1:0]  yaw;
		logic [GainW-1:0]        gain_p, gain_i, gain_d, elim, step;
		logic [LimW-1:0]         slim;

		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		in_ch.valid         = 1'b0;
		in_ch.turn_rate     = '0;
		in_ch.reverse_drive = 1'b0;
		in_ch.measured_yaw  = '0;
		in_ch.pot_prop      = '0;
		in_ch.pot_integ     = '0;
		in_ch.pot_deriv     = '0;
		tx_idle_pct         = 37;
		rx_idle_pct         = 48;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// separation threshold met exactly, then exceeded both ways
		write_settings(16'd4096, 16'd256, 16'd2048, 16'd25600, 23'd30000, 16'd6554, 1'b0);
		offer_tick(0, 1'b0, -25600, 0, 0, 0);
		offer_tick(0, 1'b0, -25601, 4095, 4095, 4095);
		offer_tick(0, 1'b1, 25601, 0, 4095, 0);
		// integral pushed into the negative clamp, then driven back positive
		offer_tick(0, 1'b0, 46080, 4095, 0, 4095);
		offer_tick(0, 1'b0, 46080, 0, 0, 0);
		offer_tick(0, 1'b0, -46080, 0, 0, 0);
		offer_tick(0, 1'b0, -46080, 4095, 4095, 4095);
		// step extremes and floor rounding of negative steps
		offer_tick(32767, 1'b0, 0, 0, 0, 0);
		offer_tick(-32768, 1'b0, 0, 0, 0, 0);
		offer_tick(-32768, 1'b1, 0, 0, 0, 0);
		offer_tick(32767, 1'b1, 0, 0, 0, 0);
		offer_tick(-1, 1'b0, 0, 0, 0, 0);
		offer_tick(1, 1'b1, 0, 0, 0, 0);
		drain_ticks();

		// potentiometer gains, a zero integral reading clears the sum
		write_settings(16'd4096, 16'd256, 16'd2048, 16'd25600, 23'd30000, 16'd6554, 1'b1);
		offer_tick(100, 1'b0, -2000, 4095, 4095, 4095);
		offer_tick(-100, 1'b1, 2000, 0, 0, 0);
		offer_tick(0, 1'b0, 500, 1, 2048, 4094);
		offer_tick(0, 1'b0, -500, 4094, 0, 1);
		drain_ticks();

		// full gains drive the output into both clip levels
		write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 23'h7FFFFF, 16'hFFFF, 1'b0);
		offer_tick(0, 1'b0, -46080, 0, 0, 0);
		offer_tick(0, 1'b0, 46080, 0, 0, 0);
		offer_tick(0, 1'b0, 46080, 0, 0, 0);
		offer_tick(0, 1'b0, -46080, 0, 0, 0);
		drain_ticks();

		for (int ph = 0; ph < RandPhases; ph++) begin
			if (ph < 4) begin
				tx_idle_pct = 37;
				rx_idle_pct = 48;
			end else if (ph < 8) begin
				tx_idle_pct = 48;
				rx_idle_pct = 37;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			if (ph == RandPhases - 2) begin
				prof = PROF_WIND_UP;
				n_items = WindUpItems;
			end else if (ph == RandPhases - 1) begin
				prof = PROF_WIND_DOWN;
				n_items = WindDownItems;
			end else begin
				prof = (ph % 2 == 0) ? PROF_NARROW : PROF_WIDE;
				n_items = PhaseItems;
			end

			if (ph == 0) begin
				write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 23'h7FFFFF, 16'hFFFF,
					1'b0);
			end else if (ph == 1) begin
				write_settings('0, '0, '0, '0, '0, '0, 1'b1);
			end else begin
				case ($urandom_range(3))
					0: gain_p = '0;
					1: gain_p = '1;
					2: gain_p = GainW'($urandom_range(1024, 8192));
					default: gain_p = GainW'($urandom);
				endcase
				case ($urandom_range(3))
					0: gain_i = '0;
					1: gain_i = '1;
					2: gain_i = GainW'($urandom_range(16, 1024));
					default: gain_i = GainW'($urandom);
				endcase
				case ($urandom_range(3))
					0: gain_d = '0;
					1: gain_d = '1;
					2: gain_d = GainW'($urandom_range(1024, 8192));
					default: gain_d = GainW'($urandom);
				endcase
				case ($urandom_range(3))
					0: elim = '0;
					1: elim = '1;
					2: elim = GainW'($urandom_range(0, 4096));
					default: elim = GainW'($urandom);
				endcase
				case ($urandom_range(3))
					0: slim = '0;
					1: slim = '1;
					2: slim = LimW'($urandom_range(0, 65535));
					default: slim = LimW'($urandom);
				endcase
				case ($urandom_range(2))
					0: step = '0;
					1: step = '1;
					default: step = GainW'($urandom);
				endcase
				// wind-up needs full steps to reach the target saturation
				if (prof == PROF_WIND_UP || prof == PROF_WIND_DOWN)
					step = '1;
				write_settings(gain_p, gain_i, gain_d, elim, slim, step, 1'($urandom));
			end

			for (int k = 0; k < n_items; k++) begin
				if ((ph == 2 || ph == 9) && k == 40)
					hold_request = HoldCycles;
				if (ph == 6 && k == 60)
					drain_ticks();
				rev = 1'($urandom);
				case (prof)
					PROF_NARROW: begin
						rate = RateW'($urandom_range(0, 1200) - 600);
						yaw  = YawW'($urandom_range(0, 6000) - 3000);
					end
					PROF_WIDE: begin
						rate = RateW'($urandom);
						yaw  = YawW'($urandom_range(0, 92160) - 46080);
					end
					PROF_WIND_UP: begin
						rate = rev ? RateW'(-$urandom_range(32000, 32768)) :
							RateW'($urandom_range(32000, 32767));
						yaw  = YawW'($urandom_range(0, 92160) - 46080);
					end
					default: begin
						rate = rev ? RateW'($urandom_range(32000, 32767)) :
							RateW'(-$urandom_range(32000, 32768));
						yaw  = YawW'($urandom_range(0, 92160) - 46080);
					end
				endcase
				if ($urandom_range(19) == 0)
					rate = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
				if ($urandom_range(19) == 0)
					yaw = $urandom_range(1) ? 17'sd46080 : -17'sd46080;
				offer_tick(rate, rev, yaw, pick_pot(), pick_pot(), pick_pot());
			end
			drain_ticks();
		end

		repeat (SettleCycles) @(negedge clk);
		if (mismatch_count == 0 && in_flight == 0)
			$display("heading_pid_with_integral_separation_tb: done, clean");
		else
			$display("heading_pid_with_integral_separation_tb: done, errors");
		$finish;
	end

endmodule
